@@ rtl/core/dgps_pkg.sv @@
// Package for the dual gain PID steering block: field widths, clamp limits,
// register indexes and the sequencer state type. No dependencies.
package dgps_pkg;

  localparam int unsigned ERR_W       = 5;   // error sample
  localparam int unsigned GAIN_W      = 11;  // every gain register
  localparam int unsigned INT_W       = 4;   // clamped integral
  localparam int unsigned CLAMP_W     = 10;  // integral before clamping
  localparam int unsigned DIFF_W      = 6;   // error change
  localparam int unsigned DTERM_W     = 11;  // minus ten times the change
  localparam int unsigned TERM_W      = 12;  // one partial product step
  localparam int unsigned SUM_W       = 20;  // kp*e + ki*i - kd*d
  localparam int unsigned ACC_W       = SUM_W + 1;
  localparam int unsigned CMD_W       = 30;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic signed [CLAMP_W-1:0] INT_LOW  = -10'sd5;
  localparam logic signed [CLAMP_W-1:0] INT_HIGH = 10'sd5;
  localparam logic signed [ERR_W-1:0]   NO_BEACON_CODE = -5'sd4;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_SELECT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_GAIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PROP_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_INT_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_DERIV_GAIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BEACON_PROP_GAIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BEACON_INT_GAIN   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BEACON_DERIV_GAIN = 3'd7;

  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(GAIN_W - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PID   = 4'b0010,
    ST_SCALE = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

endpackage

@@ rtl/core/dual_gain_pid_steering.sv @@
// Dual gain PID steering controller, top level.
// Depends on dgps_pkg.
//
// Takes one error sample per beat and returns one drive command per beat.
// Both products are formed bit-serially over the 11 gain bits through one
// shared accumulator: the PID sum in ST_PID, then the total gain in
// ST_SCALE, then a hand-off in ST_DONE that loads the output register.
// The input reopens as the result is loaded. A new sample is taken
// only once the previous one has reached the output register, so a result
// held by a stalled output blocks the input.
module dual_gain_pid_steering
  import dgps_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [GAIN_W-1:0]      cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [4:0] error_value
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [29:0] drive_command, [34:30] used_error
);

  logic                     src_sel_q;
  logic signed [GAIN_W-1:0] tot_gain_q;
  logic signed [GAIN_W-1:0] line_kp_q, line_ki_q, line_kd_q;
  logic signed [GAIN_W-1:0] bcn_kp_q, bcn_ki_q, bcn_kd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_sel_q  <= 1'b0;
      tot_gain_q <= GAIN_W'(1);
      line_kp_q  <= '0;
      line_ki_q  <= '0;
      line_kd_q  <= '0;
      bcn_kp_q   <= '0;
      bcn_ki_q   <= '0;
      bcn_kd_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SOURCE_SELECT:     src_sel_q  <= cfg_data_i[0];
        REG_TOTAL_GAIN:        tot_gain_q <= cfg_data_i;
        REG_LINE_PROP_GAIN:    line_kp_q  <= cfg_data_i;
        REG_LINE_INT_GAIN:     line_ki_q  <= cfg_data_i;
        REG_LINE_DERIV_GAIN:   line_kd_q  <= cfg_data_i;
        REG_BEACON_PROP_GAIN:  bcn_kp_q   <= cfg_data_i;
        REG_BEACON_INT_GAIN:   bcn_ki_q   <= cfg_data_i;
        REG_BEACON_DERIV_GAIN: bcn_kd_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e                    state_q, state_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic signed [INT_W-1:0]   integ_q, integ_d;
  logic signed [ERR_W-1:0]   last_q, last_d;
  logic signed [DTERM_W-1:0] dterm_q, dterm_d;
  logic [GAIN_W-1:0]         kp_sr_q, kp_sr_d, ki_sr_q, ki_sr_d, kd_sr_q, kd_sr_d;
  logic [GAIN_W-1:0]         tg_sr_q, tg_sr_d;
  logic signed [SUM_W-1:0]   mcand_q, mcand_d;
  logic signed [ACC_W-1:0]   hi_q, hi_d;
  logic [GAIN_W-1:0]         lo_q, lo_d;
  logic signed [CMD_W-1:0]   res_q, res_d;
  logic                      out_vld_q, out_vld_d;
  logic signed [CMD_W-1:0]   out_cmd_q, out_cmd_d;
  logic signed [ERR_W-1:0]   out_err_q, out_err_d;

  // sample front end
  logic signed [ERR_W-1:0]   err_in, err_map;
  logic signed [CLAMP_W-1:0] int_raw;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [INT_W-1:0]   int_clamped;
  logic                      in_acc;

  assign err_in = s_axis_tdata[ERR_W-1:0];
  assign err_map = (src_sel_q && (err_in == NO_BEACON_CODE)) ? '0 : err_in;
  assign int_raw = CLAMP_W'(integ_q) + (CLAMP_W'(err_map) <<< 3) + (CLAMP_W'(err_map) <<< 1);
  assign int_clamped = (int_raw < INT_LOW)  ? INT_W'(INT_LOW)  :
                       (int_raw > INT_HIGH) ? INT_W'(INT_HIGH) : INT_W'(int_raw);
  assign diff = DIFF_W'(err_map) - DIFF_W'(last_q);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // shared serial accumulator step
  logic                      last_bit;
  logic signed [TERM_W-1:0]  term;
  logic signed [SUM_W:0]     mc_neg;
  logic signed [ACC_W:0]     addend, step_sum;
  logic signed [ACC_W-1:0]   hi_step;
  logic [GAIN_W-1:0]         lo_step;

  assign last_bit = (cnt_q == LAST_BIT);

  always_comb begin
    term = (kp_sr_q[0] ? TERM_W'(last_q)  : '0)
         + (ki_sr_q[0] ? TERM_W'(integ_q) : '0)
         + (kd_sr_q[0] ? TERM_W'(dterm_q) : '0);
    if (last_bit) begin
      term = -term;
    end
    mc_neg = last_bit ? -(SUM_W+1)'(mcand_q) : (SUM_W+1)'(mcand_q);
    if (state_q == ST_SCALE) begin
      addend = tg_sr_q[0] ? (ACC_W+1)'(mc_neg) : '0;
    end else begin
      addend = (ACC_W+1)'(term);
    end
  end

  assign step_sum = (ACC_W+1)'(hi_q) + addend;
  assign hi_step = step_sum[ACC_W:1];
  assign lo_step = {step_sum[0], lo_q[GAIN_W-1:1]};

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    integ_d   = integ_q;
    last_d    = last_q;
    dterm_d   = dterm_q;
    kp_sr_d   = kp_sr_q;
    ki_sr_d   = ki_sr_q;
    kd_sr_d   = kd_sr_q;
    tg_sr_d   = tg_sr_q;
    mcand_d   = mcand_q;
    hi_d      = hi_q;
    lo_d      = lo_q;
    res_d     = res_q;
    out_vld_d = out_vld_q;
    out_cmd_d = out_cmd_q;
    out_err_d = out_err_q;

    if (m_axis_tvalid && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          integ_d = int_clamped;
          last_d  = err_map;
          dterm_d = -((DTERM_W'(diff) <<< 3) + (DTERM_W'(diff) <<< 1));
          kp_sr_d = src_sel_q ? bcn_kp_q : line_kp_q;
          ki_sr_d = src_sel_q ? bcn_ki_q : line_ki_q;
          kd_sr_d = src_sel_q ? bcn_kd_q : line_kd_q;
          tg_sr_d = tot_gain_q;
          hi_d    = '0;
          lo_d    = '0;
          cnt_d   = '0;
          state_d = ST_PID;
        end
      end
      ST_PID: begin
        hi_d    = hi_step;
        lo_d    = lo_step;
        kp_sr_d = kp_sr_q >> 1;
        ki_sr_d = ki_sr_q >> 1;
        kd_sr_d = kd_sr_q >> 1;
        cnt_d   = cnt_q + CNT_W'(1);
        if (last_bit) begin
          mcand_d = {hi_step[SUM_W-GAIN_W-1:0], lo_step};
          hi_d    = '0;
          lo_d    = '0;
          cnt_d   = '0;
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        hi_d    = hi_step;
        lo_d    = lo_step;
        tg_sr_d = tg_sr_q >> 1;
        cnt_d   = cnt_q + CNT_W'(1);
        if (last_bit) begin
          res_d   = {hi_step[CMD_W-GAIN_W-1:0], lo_step};
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d = 1'b1;
          out_cmd_d = res_q;
          out_err_d = last_q;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      integ_q   <= '0;
      last_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      integ_q   <= integ_d;
      last_q    <= last_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dterm_q   <= dterm_d;
    kp_sr_q   <= kp_sr_d;
    ki_sr_q   <= ki_sr_d;
    kd_sr_q   <= kd_sr_d;
    tg_sr_q   <= tg_sr_d;
    mcand_q   <= mcand_d;
    hi_q      <= hi_d;
    lo_q      <= lo_d;
    res_q     <= res_d;
    out_cmd_q <= out_cmd_d;
    out_err_q <= out_err_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(OUT_TDATA_W-CMD_W-ERR_W)'(0), out_err_q, out_cmd_q};

endmodule

@@ rtl/core/dgps_checker.sv @@
// Port-level checks for dual_gain_pid_steering, bound to the top level.
// Depends on dgps_pkg.
module dgps_checker
  import dgps_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic in_beat;
  assign in_beat = s_axis_tvalid && s_axis_tready;

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready)
    else $error("input accepted while a sample is in flight");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |-> ##2 !$rose(m_axis_tvalid))
    else $error("result appeared too soon after a sample");

  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result loaded but block not ready for the next sample");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

endmodule

bind dual_gain_pid_steering dgps_checker u_dgps_checker (.*);

@@ test/testbench.sv @@
// Self-checking testbench for dual_gain_pid_steering: drives error samples
// and register writes, predicts each drive command and checks every result beat.
// Depends on dgps_pkg and the dual_gain_pid_steering RTL.
module testbench;
  import dgps_pkg::*;

  localparam int RATE_SCALE   = 1000 / 100;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 300;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 110;

  typedef struct packed {
    logic signed [ERR_W-1:0] used_error;
    logic signed [CMD_W-1:0] drive_command;
  } steer_result_t;

  class steering_model;
    logic                     beacon_mode;
    logic signed [GAIN_W-1:0] total_gain;
    logic signed [GAIN_W-1:0] line_kp, line_ki, line_kd;
    logic signed [GAIN_W-1:0] beacon_kp, beacon_ki, beacon_kd;
    logic signed [INT_W-1:0]  integral_sum;
    logic signed [ERR_W-1:0]  last_error;
    steer_result_t            pending_commands[$];
    int                       mismatch_count;

    function new();
      beacon_mode  = 1'b0;
      total_gain   = 11'sd1;
      line_kp      = '0;
      line_ki      = '0;
      line_kd      = '0;
      beacon_kp    = '0;
      beacon_ki    = '0;
      beacon_kd    = '0;
      integral_sum = '0;
      last_error   = '0;
      mismatch_count = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
      case (idx)
        REG_SOURCE_SELECT:     beacon_mode = data[0];
        REG_TOTAL_GAIN:        total_gain  = data;
        REG_LINE_PROP_GAIN:    line_kp     = data;
        REG_LINE_INT_GAIN:     line_ki     = data;
        REG_LINE_DERIV_GAIN:   line_kd     = data;
        REG_BEACON_PROP_GAIN:  beacon_kp   = data;
        REG_BEACON_INT_GAIN:   beacon_ki   = data;
        REG_BEACON_DERIV_GAIN: beacon_kd   = data;
        default: ;
      endcase
    endfunction

    function void log_error_sample(logic signed [ERR_W-1:0] sample);
      int            ev, acc, kp, ki, kd;
      longint        pid_sum, cmd;
      steer_result_t r;
      ev = sample;
      // no beacon seen reads as zero error in beacon mode
      if (beacon_mode && sample == NO_BEACON_CODE) ev = 0;
      acc = int'(integral_sum) + ev * RATE_SCALE;
      if (acc < int'(INT_LOW)) acc = INT_LOW;
      if (acc > int'(INT_HIGH)) acc = INT_HIGH;
      integral_sum = acc[INT_W-1:0];
      if (beacon_mode) begin
        kp = beacon_kp;
        ki = beacon_ki;
        kd = beacon_kd;
      end else begin
        kp = line_kp;
        ki = line_ki;
        kd = line_kd;
      end
      pid_sum = longint'(kp) * ev + longint'(ki) * acc
              - longint'(kd) * (ev - int'(last_error)) * RATE_SCALE;
      cmd = longint'(total_gain) * pid_sum;
      last_error = ev[ERR_W-1:0];
      r.drive_command = cmd[CMD_W-1:0];
      r.used_error    = ev[ERR_W-1:0];
      pending_commands.push_back(r);
    endfunction

    task report_mismatch(string msg);
      mismatch_count++;
      $display("mismatch: %s", msg);
    endtask

    task check_drive_command(steer_result_t got);
      steer_result_t want;
      if (pending_commands.size() == 0) begin
        report_mismatch($sformatf("unexpected beat cmd=%0d used_error=%0d",
                                  got.drive_command, got.used_error));
        return;
      end
      want = pending_commands.pop_front();
      if (got.drive_command !== want.drive_command)
        report_mismatch($sformatf("drive_command got %0d want %0d",
                                  got.drive_command, want.drive_command));
      if (got.used_error !== want.used_error)
        report_mismatch($sformatf("used_error got %0d want %0d",
                                  got.used_error, want.used_error));
    endtask
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [GAIN_W-1:0]      cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  steering_model model = new();
  bit            src_idle;
  bit            sink_idle;
  bit            hold_request;

  dual_gain_pid_steering uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #12_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      model.check_drive_command(steer_result_t'(m_axis_tdata[ERR_W+CMD_W-1:0]));
  end

  initial begin : result_sink
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end else begin
        stall = sink_idle ? $urandom_range(0, 11) : 0;
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // called and returns at a falling edge
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    model.set_register(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_config(bit beacon, logic [GAIN_W-1:0] total,
                              logic [GAIN_W-1:0] lkp, logic [GAIN_W-1:0] lki,
                              logic [GAIN_W-1:0] lkd, logic [GAIN_W-1:0] bkp,
                              logic [GAIN_W-1:0] bki, logic [GAIN_W-1:0] bkd);
    write_reg(REG_SOURCE_SELECT, {{(GAIN_W-1){1'b0}}, beacon});
    write_reg(REG_TOTAL_GAIN, total);
    write_reg(REG_LINE_PROP_GAIN, lkp);
    write_reg(REG_LINE_INT_GAIN, lki);
    write_reg(REG_LINE_DERIV_GAIN, lkd);
    write_reg(REG_BEACON_PROP_GAIN, bkp);
    write_reg(REG_BEACON_INT_GAIN, bki);
    write_reg(REG_BEACON_DERIV_GAIN, bkd);
  endtask

  task automatic send_error(logic signed [ERR_W-1:0] sample);
    int gap;
    gap = src_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W-ERR_W){1'b0}}, sample};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    model.log_error_sample(sample);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (model.pending_commands.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return 11'sh400;  // -1024
      1:       return 11'sh3FF;  // 1023
      2:       return '0;
      default: return GAIN_W'($urandom_range(0, 2047));
    endcase
  endfunction

  function automatic logic signed [ERR_W-1:0] pick_error(bit beacon);
    int roll;
    roll = $urandom_range(0, 99);
    if (beacon && roll < 25) return NO_BEACON_CODE;
    if (roll < 60) return ERR_W'($signed($urandom_range(0, 2)) - 1);
    if (roll < 90) return ERR_W'($signed($urandom_range(0, 24)) - 12);
    return ERR_W'($urandom_range(0, 31));
  endfunction

  initial begin : stimulus
    logic signed [ERR_W-1:0] line_seq[];
    logic signed [ERR_W-1:0] beacon_seq[];
    logic signed [ERR_W-1:0] raw_seq[];
    bit                      beacon;
    line_seq      = '{5'sd0, 5'sd1, 5'sd12, -5'sd12, -5'sd16, 5'sd15, 5'sd0, 5'sd0, -5'sd1};
    beacon_seq    = '{-5'sd4, -5'sd4, 5'sd5, -5'sd4, -5'sd16, 5'sd15, -5'sd4, 5'sd0, 5'sd3};
    raw_seq       = '{-5'sd4, 5'sd15, -5'sd16, -5'sd4};
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    src_idle      = 1'b0;
    sink_idle     = 1'b0;
    hold_request  = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset values of the other registers still in force
    write_reg(REG_LINE_PROP_GAIN, 11'sd7);
    send_error(5'sd15);
    send_error(-5'sd16);
    drain_results();

    apply_config(1'b0, 11'sd1, 11'sd3, -11'sd2, 11'sd1, 11'sd0, 11'sd0, 11'sd0);
    foreach (line_seq[k]) send_error(line_seq[k]);
    drain_results();

    src_idle  = 1'b1;
    sink_idle = 1'b1;
    apply_config(1'b1, 11'sh400, 11'sd5, 11'sd6, 11'sd7, 11'sh3FF, 11'sh400, 11'sh3FF);
    foreach (beacon_seq[k]) send_error(beacon_seq[k]);
    drain_results();

    // -4 passes through unchanged in line mode
    apply_config(1'b0, 11'sh3FF, 11'sh400, 11'sh3FF, 11'sh400, 11'sd1, 11'sd1, 11'sd1);
    foreach (raw_seq[k]) send_error(raw_seq[k]);
    drain_results();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      beacon = $urandom_range(0, 1);
      apply_config(beacon, pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                   pick_gain(), pick_gain(), pick_gain());
      src_idle  = (ph % 4 == 1) || (ph % 4 == 2);
      sink_idle = (ph % 4 == 1) || (ph % 4 == 3);
      if (ph == 4) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_error(pick_error(beacon));
      drain_results();
    end

    if (model.mismatch_count == 0 && model.pending_commands.size() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/dgps_pkg.sv
rtl/core/dual_gain_pid_steering.sv
rtl/core/dgps_checker.sv
test/testbench.sv
